[design/psfc_pkg.sv]
// Shared types and constants for the pressure sensor frame converter.
package psfc_pkg;

    typedef enum logic [2:0] {
        REG_FRAME_BYTES   = 3'd0,
        REG_GAUGE_MODE    = 3'd1,
        REG_ZERO_OFFSET   = 3'd2,
        REG_RAW_OFFSET    = 3'd3,
        REG_SCALE         = 3'd4,
        REG_BASE_PRESSURE = 3'd5,
        REG_LOW_LIMIT     = 3'd6,
        REG_HIGH_LIMIT    = 3'd7
    } reg_idx_t;

    localparam logic [2:0] STATUS_INVALID_LEN = 3'd4;

    localparam logic [2:0]  FRAME_BYTES_RST = 3'd2;
    localparam logic [31:0] SCALE_RST       = 32'd16777216;

    // Temperature: t = m + floor((m + 1023) / 2047) - 50.0 in Q16.16, m = raw * 6400.
    // The division by 2047 is a multiply by a rounded-up reciprocal of 2^35 / 2047.
    localparam logic [23:0] TEMP_ROUND  = 24'd1023;
    localparam logic [24:0] TEMP_RECIP  = 25'd16785413;
    localparam int          TEMP_SHIFT  = 35;
    localparam logic [25:0] TEMP_BIAS   = 26'd3276800;
    localparam logic signed [24:0] TEMP_MIN = -25'sd3276800;
    localparam logic signed [24:0] TEMP_MAX = 25'sd9830400;

    typedef struct packed {
        logic [2:0]         frame_bytes;
        logic               gauge_mode;
        logic [15:0]        zero_offset;
        logic [13:0]        raw_offset;
        logic signed [31:0] scale;
        logic signed [31:0] base_pressure;
        logic signed [31:0] low_limit;
        logic signed [31:0] high_limit;
    } cfg_t;

    // Decoded frame handed from the framer to the converter.
    typedef struct packed {
        logic [2:0]         status_code;
        logic [13:0]        raw_pressure;
        logic [10:0]        raw_temperature;
        logic signed [17:0] count_diff;   // adjusted raw minus raw_offset
        logic [23:0]        temp_lin;     // raw_temperature * 6400
    } frame_t;

    typedef struct packed {
        logic               within_limits;
        logic               above_limit;
        logic               below_limit;
        logic signed [24:0] temperature_value;
        logic signed [31:0] pressure_value;
        logic [10:0]        raw_temperature;
        logic [13:0]        raw_pressure;
        logic [2:0]         status_code;
    } result_t;

endpackage

[design/psfc_regs.sv]
// Configuration register file with an APB-style write/read port.
module psfc_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output psfc_pkg::cfg_t      cfg
);
    import psfc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_bytes   <= FRAME_BYTES_RST;
            cfg_reg.gauge_mode    <= 1'b0;
            cfg_reg.zero_offset   <= '0;
            cfg_reg.raw_offset    <= '0;
            cfg_reg.scale         <= SCALE_RST;
            cfg_reg.base_pressure <= '0;
            cfg_reg.low_limit     <= '0;
            cfg_reg.high_limit    <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_FRAME_BYTES:   cfg_reg.frame_bytes   <= pwdata[2:0];
                REG_GAUGE_MODE:    cfg_reg.gauge_mode    <= pwdata[0];
                REG_ZERO_OFFSET:   cfg_reg.zero_offset   <= pwdata[15:0];
                REG_RAW_OFFSET:    cfg_reg.raw_offset    <= pwdata[13:0];
                REG_SCALE:         cfg_reg.scale         <= pwdata;
                REG_BASE_PRESSURE: cfg_reg.base_pressure <= pwdata;
                REG_LOW_LIMIT:     cfg_reg.low_limit     <= pwdata;
                REG_HIGH_LIMIT:    cfg_reg.high_limit    <= pwdata;
                default:           cfg_reg.frame_bytes   <= cfg_reg.frame_bytes;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FRAME_BYTES:   prdata = {29'd0, cfg_reg.frame_bytes};
            REG_GAUGE_MODE:    prdata = {31'd0, cfg_reg.gauge_mode};
            REG_ZERO_OFFSET:   prdata = {16'd0, cfg_reg.zero_offset};
            REG_RAW_OFFSET:    prdata = {18'd0, cfg_reg.raw_offset};
            REG_SCALE:         prdata = cfg_reg.scale;
            REG_BASE_PRESSURE: prdata = cfg_reg.base_pressure;
            REG_LOW_LIMIT:     prdata = cfg_reg.low_limit;
            REG_HIGH_LIMIT:    prdata = cfg_reg.high_limit;
            default:           prdata = '0;
        endcase
    end

endmodule

[design/psfc_framer.sv]
// Byte gathering, frame decode and raw count offsetting into the first pipeline register.
module psfc_framer (
    input  logic             aclk,
    input  logic             aresetn,
    input  psfc_pkg::cfg_t   cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    output logic             frm_valid,
    input  logic             frm_ready,
    output psfc_pkg::frame_t frm
);
    import psfc_pkg::*;

    logic [2:0]  byte_count_reg, byte_count_next;
    logic [31:0] shift_reg, shift_next;
    logic        valid_reg, valid_next;
    frame_t      frm_reg, frm_next;

    logic [2:0]  frame_len;
    logic        accept;
    logic        frame_done;
    logic [13:0] rawp;
    logic [10:0] rawt;
    logic [2:0]  status;
    logic [17:0] zero_sub;

    assign s_tready  = !valid_reg || frm_ready;
    assign accept    = s_tvalid && s_tready;
    assign frame_len = (cfg.frame_bytes == 3'd0) ? 3'd1 : cfg.frame_bytes;
    assign shift_next = {shift_reg[23:0], s_tdata};
    assign frame_done = ({1'b0, byte_count_reg} + 4'd1) >= {1'b0, frame_len};

    always_comb begin
        unique case (frame_len)
            3'd2: begin
                status = {1'b0, shift_next[15:14]};
                rawp   = shift_next[13:0];
                rawt   = '0;
            end
            3'd3: begin
                status = {1'b0, shift_next[23:22]};
                rawp   = shift_next[21:8];
                rawt   = {shift_next[7:0], 3'b000};
            end
            3'd4: begin
                status = {1'b0, shift_next[31:30]};
                rawp   = shift_next[29:16];
                rawt   = shift_next[15:5];
            end
            default: begin
                status = STATUS_INVALID_LEN;
                rawp   = '0;
                rawt   = '0;
            end
        endcase
    end

    assign zero_sub = cfg.gauge_mode ? {2'b00, cfg.zero_offset} : 18'd0;

    always_comb begin
        frm_next.status_code     = status;
        frm_next.raw_pressure    = rawp;
        frm_next.raw_temperature = rawt;
        frm_next.count_diff      = $signed({4'b0000, rawp} - zero_sub
                                           - {4'b0000, cfg.raw_offset});
        frm_next.temp_lin        = (24'(rawt) << 12) + (24'(rawt) << 11) + (24'(rawt) << 8);
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        valid_next      = valid_reg;
        if (frm_ready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            byte_count_next = frame_done ? 3'd0 : byte_count_reg + 3'd1;
            if (frame_done) begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            shift_reg      <= '0;
            valid_reg      <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            valid_reg      <= valid_next;
            if (accept) begin
                shift_reg <= shift_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && frame_done) begin
            frm_reg <= frm_next;
        end
    end

    assign frm_valid = valid_reg;
    assign frm       = frm_reg;

endmodule

[design/psfc_convert.sv]
// Transfer function, temperature scaling and limit checks: product stage and result register.
module psfc_convert (
    input  logic              aclk,
    input  logic              aresetn,
    input  psfc_pkg::cfg_t    cfg,
    input  logic              frm_valid,
    output logic              frm_ready,
    input  psfc_pkg::frame_t  frm,
    output logic              res_valid,
    input  logic              res_ready,
    output psfc_pkg::result_t res
);
    import psfc_pkg::*;

    localparam logic signed [50:0] P_MAX = 51'sd2147483647;
    localparam logic signed [50:0] P_MIN = -51'sd2147483648;

    // Product stage
    logic               mul_valid_reg;
    frame_t             mul_frm_reg;
    logic signed [49:0] mul_prod_reg, mul_prod_next;
    logic [13:0]        mul_tq_reg, mul_tq_next;
    logic [48:0]        tq_wide;
    logic               mul_ready;

    // Result stage
    logic               res_valid_reg;
    result_t            res_reg, res_next;
    logic               out_ready;

    logic signed [50:0] acc;
    logic signed [50:0] p_wide;
    logic signed [31:0] p_sat;
    logic [25:0]        t_sum;
    logic               lim_ord;
    logic               in_fwd, in_rev;

    assign out_ready = !res_valid_reg || res_ready;
    assign mul_ready = !mul_valid_reg || out_ready;
    assign frm_ready = mul_ready;

    assign mul_prod_next = 50'(frm.count_diff) * 50'(cfg.scale);
    assign tq_wide       = 49'(frm.temp_lin + TEMP_ROUND) * 49'(TEMP_RECIP);
    assign mul_tq_next   = tq_wide[TEMP_SHIFT +: 14];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (mul_ready) begin
                mul_valid_reg <= frm_valid;
            end
            if (out_ready) begin
                res_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && frm_valid) begin
            mul_frm_reg  <= frm;
            mul_prod_reg <= mul_prod_next;
            mul_tq_reg   <= mul_tq_next;
        end
        if (out_ready && mul_valid_reg) begin
            res_reg <= res_next;
        end
    end

    // Round Q24 to Q16.16 with halves up, then clamp.
    assign acc    = (51'(cfg.base_pressure) <<< 8) + 51'(mul_prod_reg) + 51'sd128;
    assign p_wide = acc >>> 8;

    always_comb begin
        priority if (p_wide > P_MAX) begin
            p_sat = P_MAX[31:0];
        end else if (p_wide < P_MIN) begin
            p_sat = P_MIN[31:0];
        end else begin
            p_sat = p_wide[31:0];
        end
    end

    assign t_sum   = 26'(mul_frm_reg.temp_lin) + 26'(mul_tq_reg) - TEMP_BIAS;
    assign lim_ord = cfg.low_limit <= cfg.high_limit;
    assign in_fwd  = (p_sat >= cfg.low_limit) && (p_sat <= cfg.high_limit);
    assign in_rev  = (p_sat >= cfg.high_limit) && (p_sat <= cfg.low_limit);

    always_comb begin
        res_next.status_code       = mul_frm_reg.status_code;
        res_next.raw_pressure      = mul_frm_reg.raw_pressure;
        res_next.raw_temperature   = mul_frm_reg.raw_temperature;
        res_next.pressure_value    = p_sat;
        res_next.temperature_value = $signed(t_sum[24:0]);
        res_next.below_limit       = p_sat < cfg.low_limit;
        res_next.above_limit       = p_sat > cfg.high_limit;
        res_next.within_limits     = lim_ord ? in_fwd : in_rev;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[design/pressure_sensor_frame_converter.sv]
// Top level of the pressure sensor frame converter.
// Sensor bytes enter on the s_ stream, one byte per cycle while s_tready is high, most
// significant byte first, and are gathered into frames of frame_bytes bytes (2, 3 or 4; 0
// acts as 1, and any other length gives status 4 with zero raw fields). Each completed frame
// produces one result on the m_ stream after passing a decode register, a product register
// holding the 18x32 pressure multiply and the temperature reciprocal multiply, and the
// result register where rounding, saturation and the limit compares finish. Every stage
// advances on its own, so a byte is taken in every cycle while a result waits, until all
// three stages hold a frame. Configure through the APB port only while no frame is in flight.
module pressure_sensor_frame_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status_code, [16:3] raw_pressure, [27:17] raw_temperature,
    // [59:28] pressure_value, [84:60] temperature_value, [85] below_limit,
    // [86] above_limit, [87] within_limits
    output logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import psfc_pkg::*;

    cfg_t    cfg;
    frame_t  frm;
    logic    frm_valid;
    logic    frm_ready;
    result_t res;

    psfc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psfc_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm)
    );

    psfc_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .frm_valid (frm_valid),
        .frm_ready (frm_ready),
        .frm       (frm),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = res;

    // An empty result register means the whole pipeline can take a byte.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_invalid_len_zero_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res.status_code == STATUS_INVALID_LEN)
            |-> (res.raw_pressure == '0) && (res.raw_temperature == '0))
        else $error("invalid-length frame carries raw data");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.temperature_value >= TEMP_MIN) && (res.temperature_value <= TEMP_MAX))
        else $error("temperature out of range");

    a_below_above: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (cfg.low_limit <= cfg.high_limit)
            |-> !(res.within_limits && (res.below_limit || res.above_limit)))
        else $error("limit flags disagree");

endmodule

[sim/pressure_sensor_frame_converter_tb.sv]
// Self-checking testbench for the pressure sensor frame converter: byte stream in, results checked.
`timescale 1ns / 1ps

module pressure_sensor_frame_converter_tb;
    import psfc_pkg::*;

    localparam int     BYTE_TARGET = 1000;
    localparam int     DRAIN       = 8;
    localparam int     LONG_HOLD   = 300;
    localparam int     CYCLE_LIMIT = 500000;
    localparam longint P_MAX       = 64'sh0000_0000_7FFF_FFFF;
    localparam longint P_MIN       = -64'sh0000_0000_8000_0000;
    localparam longint T_COLD      = -64'sd3276800;

    typedef struct {
        bit          is_cfg;
        reg_idx_t    idx;
        logic [31:0] val;
        bit          typed;
        result_t     exp;
    } script_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block: registers, byte counter, shift word
    cfg_t        shadow_cfg;
    logic [2:0]  gathered;
    logic [31:0] shift_word;

    result_t     pending_results[$];
    script_row_t script[$];
    int          mismatches = 0;
    int          cycles     = 0;
    bit          tx_quiet   = 1'b0;
    bit          rx_quiet   = 1'b0;
    bit          hold_request = 1'b0;

    pressure_sensor_frame_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // signed word: extremes or zero now and then, sometimes any word, else a value within +/- 2^spread
    function automatic logic [31:0] pick_word(input int spread);
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom;
            default: begin
                v = $urandom_range(0, (1 << spread) - 1);
                return $urandom_range(0, 1) ? v : -v;
            end
        endcase
    endfunction

    function automatic result_t make_result(input logic [2:0] st, input int rp, input int rt,
                                            input longint p, input longint t,
                                            input bit b, input bit a, input bit w);
        result_t r;
        r.status_code       = st;
        r.raw_pressure      = rp[13:0];
        r.raw_temperature   = rt[10:0];
        r.pressure_value    = p[31:0];
        r.temperature_value = t[24:0];
        r.below_limit       = b;
        r.above_limit       = a;
        r.within_limits     = w;
        return r;
    endfunction

    // Shift one byte into the frame; return 1 with the converted reading when it completes.
    function automatic bit convert_byte(input logic [7:0] b, output result_t r);
        logic [2:0]  len;
        logic [31:0] w;
        logic [2:0]  st;
        logic [13:0] rawp;
        logic [10:0] rawt;
        longint      adj, acc, p, t, lim_lo, lim_hi, lo, hi;
        shift_word = {shift_word[23:0], b};
        len = (shadow_cfg.frame_bytes == 3'd0) ? 3'd1 : shadow_cfg.frame_bytes;
        if (int'(gathered) + 1 < int'(len)) begin
            gathered = gathered + 3'd1;
            return 1'b0;
        end
        gathered = 3'd0;
        w = shift_word;
        case (len)
            3'd2: begin
                st = {1'b0, w[15:14]}; rawp = w[13:0]; rawt = 11'd0;
            end
            3'd3: begin
                st = {1'b0, w[23:22]}; rawp = w[21:8]; rawt = {w[7:0], 3'b000};
            end
            3'd4: begin
                st = {1'b0, w[31:30]}; rawp = w[29:16]; rawt = w[15:5];
            end
            default: begin
                st = STATUS_INVALID_LEN; rawp = 14'd0; rawt = 11'd0;
            end
        endcase
        adj = longint'(rawp);
        if (shadow_cfg.gauge_mode)
            adj = adj - longint'(shadow_cfg.zero_offset);
        acc = longint'(shadow_cfg.base_pressure) * 256
            + (adj - longint'(shadow_cfg.raw_offset)) * longint'(shadow_cfg.scale);
        p = (acc + 128) >>> 8;
        if (p > P_MAX)
            p = P_MAX;
        if (p < P_MIN)
            p = P_MIN;
        t = (longint'(rawt) * 13107200 + 1023) / 2047 - 3276800;
        lim_lo = longint'(shadow_cfg.low_limit);
        lim_hi = longint'(shadow_cfg.high_limit);
        lo = (lim_lo < lim_hi) ? lim_lo : lim_hi;
        hi = (lim_lo < lim_hi) ? lim_hi : lim_lo;
        r = make_result(st, int'(rawp), int'(rawt), p, t, p < lim_lo, p > lim_hi,
                        (p >= lo) && (p <= hi));
        return 1'b1;
    endfunction

    function automatic void add_cfg(input reg_idx_t idx, input logic [31:0] v);
        script_row_t row;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = v;
        row.typed  = 1'b0;
        row.exp    = '0;
        script.push_back(row);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input bit typed, input result_t e);
        script_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = REG_FRAME_BYTES;
        row.val    = {24'd0, b};
        row.typed  = typed;
        row.exp    = e;
        script.push_back(row);
    endfunction

    // Drop valid, wait for every result and the pipeline to drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_BYTES:   shadow_cfg.frame_bytes   = v[2:0];
            REG_GAUGE_MODE:    shadow_cfg.gauge_mode    = v[0];
            REG_ZERO_OFFSET:   shadow_cfg.zero_offset   = v[15:0];
            REG_RAW_OFFSET:    shadow_cfg.raw_offset    = v[13:0];
            REG_SCALE:         shadow_cfg.scale         = v;
            REG_BASE_PRESSURE: shadow_cfg.base_pressure = v;
            REG_LOW_LIMIT:     shadow_cfg.low_limit     = v;
            REG_HIGH_LIMIT:    shadow_cfg.high_limit    = v;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t e);
        int      gap;
        result_t pred;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (convert_byte(b, pred))
            pending_results.push_back(typed ? e : pred);
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            mismatches++;
        end
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        int g;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                g = pick_gap(rx_quiet);
                if (g > 0) begin
                    m_tready <= 1'b0;
                    stall = g - 1;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: %0h", m_tdata);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                check_field("status_code", 32'(e.status_code), 32'(got.status_code));
                check_field("raw_pressure", 32'(e.raw_pressure), 32'(got.raw_pressure));
                check_field("raw_temperature", 32'(e.raw_temperature),
                            32'(got.raw_temperature));
                check_field("pressure_value", e.pressure_value, got.pressure_value);
                check_field("temperature_value", 32'(e.temperature_value),
                            32'(got.temperature_value));
                check_field("below_limit", 32'(e.below_limit), 32'(got.below_limit));
                check_field("above_limit", 32'(e.above_limit), 32'(got.above_limit));
                check_field("within_limits", 32'(e.within_limits), 32'(got.within_limits));
            end
        end
    end

    initial begin
        result_t     none;
        result_t     cold_zero;
        result_t     bad_len;
        int          sent;
        int          n;
        bit          first_phase;
        logic [2:0]  odd_len[5];
        none        = '0;
        sent        = 0;
        first_phase = 1'b1;
        odd_len     = '{3'd0, 3'd1, 3'd5, 3'd6, 3'd7};

        shadow_cfg               = '0;
        shadow_cfg.frame_bytes   = FRAME_BYTES_RST;
        shadow_cfg.scale         = SCALE_RST;
        gathered                 = 3'd0;
        shift_word               = 32'd0;

        cold_zero = make_result(3'd0, 0, 0, 0, T_COLD, 1'b0, 1'b0, 1'b1);
        bad_len   = make_result(STATUS_INVALID_LEN, 0, 0, 0, T_COLD, 1'b0, 1'b0, 1'b1);

        // reset values: two-byte frames, unit scale, limits at zero
        add_byte(8'h00, 1'b0, none);
        add_byte(8'h00, 1'b1, cold_zero);
        add_byte(8'hFF, 1'b0, none);
        add_byte(8'hFF, 1'b1, make_result(3'd3, 16383, 0, 64'sd1073676288, T_COLD,
                                          1'b0, 1'b1, 1'b0));
        // invalid lengths: one byte, zero acting as one, five bytes
        add_cfg(REG_FRAME_BYTES, 32'd1);
        add_byte(8'hA5, 1'b1, bad_len);
        add_cfg(REG_FRAME_BYTES, 32'd0);
        add_byte(8'h5A, 1'b1, bad_len);
        add_cfg(REG_FRAME_BYTES, 32'd5);
        add_byte(8'h11, 1'b0, none);
        add_byte(8'h22, 1'b0, none);
        add_byte(8'h33, 1'b0, none);
        add_byte(8'h44, 1'b0, none);
        add_byte(8'h55, 1'b1, bad_len);
        // three- and four-byte frames, full-scale temperature
        add_cfg(REG_FRAME_BYTES, 32'd3);
        add_byte(8'h7F, 1'b0, none);
        add_byte(8'hFF, 1'b0, none);
        add_byte(8'hFF, 1'b0, none);
        add_cfg(REG_FRAME_BYTES, 32'd4);
        add_byte(8'h80, 1'b0, none);
        add_byte(8'h00, 1'b0, none);
        add_byte(8'hFF, 1'b0, none);
        add_byte(8'hFF, 1'b0, none);
        // length shortened with two bytes already gathered
        add_byte(8'h12, 1'b0, none);
        add_byte(8'h34, 1'b0, none);
        add_cfg(REG_FRAME_BYTES, 32'd2);
        add_byte(8'h56, 1'b0, none);
        // gauge mode with the largest offsets: saturate low, then high; swapped limits
        add_cfg(REG_GAUGE_MODE, 32'd1);
        add_cfg(REG_ZERO_OFFSET, 32'h0000_FFFF);
        add_cfg(REG_RAW_OFFSET, 32'h0000_3FFF);
        add_cfg(REG_SCALE, 32'h7FFF_FFFF);
        add_cfg(REG_BASE_PRESSURE, 32'h8000_0000);
        add_cfg(REG_LOW_LIMIT, 32'h7FFF_FFFF);
        add_cfg(REG_HIGH_LIMIT, 32'h8000_0000);
        add_byte(8'h00, 1'b0, none);
        add_byte(8'h00, 1'b0, none);
        add_cfg(REG_SCALE, 32'h8000_0000);
        add_cfg(REG_BASE_PRESSURE, 32'h7FFF_FFFF);
        add_byte(8'h00, 1'b0, none);
        add_byte(8'h00, 1'b0, none);

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].idx, script[i].val);
            end else begin
                send_byte(script[i].val[7:0], script[i].typed, script[i].exp);
            end
        end

        while (sent < BYTE_TARGET) begin
            settle();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (first_phase)
                write_reg(REG_FRAME_BYTES, 32'd2);
            else if ($urandom_range(0, 4) == 0)
                write_reg(REG_FRAME_BYTES, {29'd0, odd_len[$urandom_range(0, 4)]});
            else
                write_reg(REG_FRAME_BYTES, $urandom_range(2, 4));
            write_reg(REG_GAUGE_MODE, $urandom_range(0, 1));
            write_reg(REG_ZERO_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                    : $urandom_range(0, 16383));
            write_reg(REG_RAW_OFFSET, $urandom_range(0, 16383));
            write_reg(REG_SCALE, pick_word(24));
            write_reg(REG_BASE_PRESSURE, pick_word(30));
            write_reg(REG_LOW_LIMIT, pick_word(30));
            write_reg(REG_HIGH_LIMIT, pick_word(30));
            n = $urandom_range(20, 120);
            if (first_phase) begin
                // keep offering bytes while the result side holds off
                tx_quiet     = 1'b1;
                hold_request = 1'b1;
                n            = 80;
                first_phase  = 1'b0;
            end
            repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, none);
            sent += n;
        end

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
